// ----- rtl/cftrk_pkg.sv -----
// ----------------------------------------------------------------------------
// cftrk_pkg
// Shared types and constants of the credit flow control tracker.
// ----------------------------------------------------------------------------
package cftrk_pkg;

  localparam int unsigned TIME_W = 48;
  localparam int unsigned LAT_W  = 16;
  localparam int unsigned NEED_W = 10;
  localparam int unsigned CRED_W = 8;
  localparam int unsigned CNT_W  = 8;

  localparam logic [TIME_W-1:0] TIME_MAX        = {TIME_W{1'b1}};
  localparam logic [CRED_W-1:0] MAX_CREDITS_RST = 8'd12;

  typedef struct packed {
    logic [TIME_W-1:0] current_time;
    logic [LAT_W-1:0]  credit_latency;
    logic [NEED_W-1:0] credits_needed;
  } req_t;

  typedef struct packed {
    logic [TIME_W-1:0] queue_delay;
    logic [CRED_W-1:0] credits_left;
    logic [CNT_W-1:0]  entries_in_flight;
  } rsp_t;

  // One in-flight batch
  typedef struct packed {
    logic [TIME_W-1:0] done_time;
    logic [CRED_W-1:0] credits;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RWAIT,
    ST_RCHK,
    ST_BATCH,
    ST_HWAIT,
    ST_WAIT,
    ST_ACC,
    ST_CHARGE,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic load;
    logic pop;
    logic wait_calc;
    logic acc;
    logic refill;
    logic charge;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic head_due;
    logic short_credits;
    logic rem_zero;
    logic use_zero;
  } dp_stat_t;

endpackage

// ----- rtl/cftrk_chan_if.sv -----
// ----------------------------------------------------------------------------
// cftrk_chan_if
// Valid/ready channel carrying one payload of type T per transaction.
// ----------------------------------------------------------------------------
interface cftrk_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/cftrk_ctrl.sv -----
// ----------------------------------------------------------------------------
// cftrk_ctrl
// Sequencer: return due batches, split the request, stall on the head,
// charge and push, then hand the result to the output register.
// ----------------------------------------------------------------------------
module cftrk_ctrl
  import cftrk_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  output logic      req_ready_o,
  input  logic      rsp_ready_i,
  output logic      rsp_valid_o,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   valid_q, valid_d;
  logic   can_load;

  assign can_load = !valid_q || rsp_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (req_valid_i) state_d = ST_RWAIT;
      ST_RWAIT:  state_d = ST_RCHK;
      ST_RCHK: begin
        if (!stat_i.cnt_zero && stat_i.head_due) state_d = ST_RWAIT;
        else                                     state_d = ST_BATCH;
      end
      ST_BATCH: begin
        if (stat_i.rem_zero)           state_d = ST_FIN;
        else if (!stat_i.short_credits) state_d = ST_CHARGE;
        else if (!stat_i.cnt_zero)     state_d = ST_HWAIT;
        else                           state_d = ST_CHARGE;
      end
      ST_HWAIT:  state_d = ST_WAIT;
      ST_WAIT:   state_d = ST_ACC;
      ST_ACC:    state_d = ST_RCHK;
      ST_CHARGE: state_d = stat_i.use_zero ? ST_FIN : ST_BATCH;
      ST_FIN:    if (can_load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        cmd_o.load  = req_valid_i;
      end
      ST_RCHK:   cmd_o.pop = !stat_i.cnt_zero && stat_i.head_due;
      ST_BATCH: begin
        cmd_o.refill = !stat_i.rem_zero && stat_i.short_credits && stat_i.cnt_zero;
      end
      ST_WAIT:   cmd_o.wait_calc = 1'b1;
      ST_ACC:    cmd_o.acc = 1'b1;
      ST_CHARGE: cmd_o.charge = 1'b1;
      ST_FIN:    cmd_o.out_load = can_load;
      default: begin
        cmd_o       = '0;
        req_ready_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (cmd_o.out_load)   valid_d = 1'b1;
    else if (rsp_ready_i) valid_d = 1'b0;
  end

  assign rsp_valid_o = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

endmodule

// ----- rtl/cftrk_dp.sv -----
// ----------------------------------------------------------------------------
// cftrk_dp
// Datapath: batch memory, head/tail pointers, credit pool, time and delay
// arithmetic, result register.
// ----------------------------------------------------------------------------
module cftrk_dp
  import cftrk_pkg::*;
#(
  parameter int unsigned CREDIT_DEPTH = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CRED_W-1:0] cfg_data_i,
  input  req_t              req_data_i,
  input  ctrl_cmd_t         cmd_i,
  output dp_stat_t          stat_o,
  output rsp_t              rsp_data_o
);

  localparam int unsigned PTR_W = (CREDIT_DEPTH > 1) ? $clog2(CREDIT_DEPTH) : 1;
  localparam int unsigned FCT_W = $clog2(CREDIT_DEPTH + 1);
  localparam logic [CRED_W-1:0] DEPTH_CAP =
    (CREDIT_DEPTH > 255) ? 8'd255 : CRED_W'(CREDIT_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CREDIT_DEPTH - 1);
  localparam logic [FCT_W-1:0] CNT_FULL = FCT_W'(CREDIT_DEPTH);

  function automatic logic [CRED_W-1:0] pool_of(input logic [CRED_W-1:0] m);
    logic [CRED_W-1:0] p;
    p = m;
    if (p == '0) p = 8'd1;
    if (p > DEPTH_CAP) p = DEPTH_CAP;
    return p;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  entry_t mem_q [CREDIT_DEPTH];
  entry_t rd_q;

  logic [CRED_W-1:0] max_q, max_d;
  logic [CRED_W-1:0] free_q, free_d;
  logic [PTR_W-1:0]  head_q, head_d, tail_q, tail_d;
  logic [FCT_W-1:0]  cnt_q, cnt_d;

  logic [TIME_W-1:0] now_q, delay_q, wait_q;
  logic [LAT_W-1:0]  lat_q;
  logic [NEED_W-1:0] rem_q;
  rsp_t              out_q;

  logic [CRED_W-1:0] pool, batch, use_cr;
  logic [CRED_W:0]   ret_sum;
  logic [TIME_W:0]   dly_sum, done_sum;
  logic              head_later, push_ok;
  entry_t            wr_entry;

  assign pool       = pool_of(max_q);
  assign batch      = (rem_q < NEED_W'(pool)) ? CRED_W'(rem_q) : pool;
  assign use_cr     = (batch < free_q) ? batch : free_q;
  assign ret_sum    = {1'b0, free_q} + {1'b0, rd_q.credits};
  assign head_later = rd_q.done_time > now_q;
  assign dly_sum    = {1'b0, delay_q} + {1'b0, wait_q};
  assign done_sum   = {1'b0, now_q} + (TIME_W + 1)'(lat_q);
  assign push_ok    = cnt_q != CNT_FULL;

  assign wr_entry.done_time = done_sum[TIME_W] ? TIME_MAX : done_sum[TIME_W-1:0];
  assign wr_entry.credits   = use_cr;

  assign stat_o.cnt_zero      = cnt_q == '0;
  assign stat_o.head_due      = !head_later;
  assign stat_o.short_credits = free_q < batch;
  assign stat_o.rem_zero      = rem_q == '0;
  assign stat_o.use_zero      = use_cr == '0;

  assign rsp_data_o = out_q;

  // Pool and FIFO bookkeeping
  always_comb begin
    max_d  = max_q;
    free_d = free_q;
    head_d = head_q;
    tail_d = tail_q;
    cnt_d  = cnt_q;
    if (cfg_we_i) begin
      max_d  = cfg_data_i;
      free_d = pool_of(cfg_data_i);
      head_d = '0;
      tail_d = '0;
      cnt_d  = '0;
    end else if (cmd_i.refill) begin
      free_d = pool;
    end else if (cmd_i.pop) begin
      free_d = (ret_sum > {1'b0, pool}) ? pool : ret_sum[CRED_W-1:0];
      head_d = ptr_inc(head_q);
      cnt_d  = cnt_q - 1'b1;
    end else if (cmd_i.charge) begin
      free_d = free_q - use_cr;
      if (push_ok) begin
        tail_d = ptr_inc(tail_q);
        cnt_d  = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q  <= MAX_CREDITS_RST;
      free_q <= pool_of(MAX_CREDITS_RST);
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      max_q  <= max_d;
      free_q <= free_d;
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

  // Batch memory: one write port at the tail, registered read at the head
  always_ff @(posedge clk_i) begin
    if (cmd_i.charge && push_ok) mem_q[tail_q] <= wr_entry;
    rd_q <= mem_q[head_q];
  end

  // Per-request working registers and result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      now_q   <= req_data_i.current_time;
      lat_q   <= req_data_i.credit_latency;
      rem_q   <= req_data_i.credits_needed;
      delay_q <= '0;
    end
    if (cmd_i.wait_calc) begin
      wait_q <= head_later ? rd_q.done_time - now_q : '0;
      if (head_later) now_q <= rd_q.done_time;
    end
    if (cmd_i.acc) begin
      delay_q <= dly_sum[TIME_W] ? TIME_MAX : dly_sum[TIME_W-1:0];
    end
    if (cmd_i.charge) begin
      rem_q <= rem_q - NEED_W'(use_cr);
    end
    if (cmd_i.out_load) begin
      out_q.queue_delay       <= delay_q;
      out_q.credits_left      <= free_q;
      out_q.entries_in_flight <= CNT_W'(cnt_q);
    end
  end

endmodule

// ----- rtl/credit_flow_control_tracker_top.sv -----
// ----------------------------------------------------------------------------
// credit_flow_control_tracker_top
// Credit-based flow control tracker with an in-flight batch FIFO.
// ----------------------------------------------------------------------------
// One request is taken at a time and yields one response. A request passes
// through acceptance, the first head lookup, a return step for every batch
// returned from the head of the FIFO, a push step for every batch pushed, a
// stall each time a batch must wait on the head completion (the failed
// credit check, the head read, the wait, the delay update and the closing
// head check), and a close-out. The close-out also holds while the previous
// response still waits for the sink. A request of zero credits pushes no
// batch. Every head move is followed by a registered read of the single
// read port of the batch memory, whose data must settle before the next
// completion compare. The response sits in an output register, so a new
// request is taken while the previous response still waits for the sink.
// Writes to max_credits are always taken, empty the FIFO and refill the
// pool; issue them only while idle. No clearing pass follows reset: the
// FIFO starts empty.
// ----------------------------------------------------------------------------
module credit_flow_control_tracker_top
  import cftrk_pkg::*;
#(
  parameter int unsigned CREDIT_DEPTH = 128
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  cftrk_chan_if.sink   req,
  cftrk_chan_if.source rsp,
  cftrk_chan_if.sink   cfg
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  logic      cfg_we;

  // Configuration never stalls
  assign cfg.ready = 1'b1;
  assign cfg_we    = cfg.valid;

  // Sequence the request through return, split, stall and push steps
  cftrk_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req.valid),
    .req_ready_o (req.ready),
    .rsp_ready_i (rsp.ready),
    .rsp_valid_o (rsp.valid),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Hold the batch FIFO, credit pool and per-transaction arithmetic
  cftrk_dp #(
    .CREDIT_DEPTH (CREDIT_DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg.data),
    .req_data_i (req.data),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .rsp_data_o (rsp.data)
  );

endmodule

// ----- rtl/cftrk_checker.sv -----
// ----------------------------------------------------------------------------
// cftrk_checker
// Port-level checks of the credit flow control tracker.
// ----------------------------------------------------------------------------
module cftrk_checker
  import cftrk_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic req_valid_i,
  input logic req_ready_i,
  input logic rsp_valid_i,
  input logic rsp_ready_i,
  input rsp_t rsp_data_i
);

  // Stalled response holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_data_i))
    else $error("response dropped or changed while stalled");

  // One transaction at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request accepted while busy");

  // A fresh response leaves the input side open
  a_ready_with_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_i) |-> req_ready_i)
    else $error("input blocked while response waits");

  // An empty FIFO leaves credits free
  a_empty_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_data_i.entries_in_flight == '0 |-> rsp_data_i.credits_left != '0)
    else $error("no credits free with nothing in flight");

endmodule

bind credit_flow_control_tracker_top cftrk_checker u_cftrk_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req.valid),
  .req_ready_i (req.ready),
  .rsp_valid_i (rsp.valid),
  .rsp_ready_i (rsp.ready),
  .rsp_data_i  (rsp.data)
);

// ----- tb/credit_status_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// credit_status_checker
// Watches the request, response and max_credits channels of the tracker,
// predicts the status each request yields and compares it with the response.
// ----------------------------------------------------------------------------
module credit_status_checker
  import cftrk_pkg::*;
#(
  parameter int unsigned DEPTH = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  input  logic                req_ready_i,
  input  req_t                req_data_i,
  input  logic                rsp_valid_i,
  input  logic                rsp_ready_i,
  input  rsp_t                rsp_data_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CRED_W-1:0]   cfg_data_i,
  output int unsigned         err_count_o,
  output int unsigned         pending_o,
  output int unsigned         checked_o
);

  localparam logic [63:0] TIME_SAT = {16'd0, TIME_MAX};
  localparam int unsigned STATUS_DEPTH = 8;
  localparam int unsigned STATUS_PTR_W = $clog2(STATUS_DEPTH);

  // Predicted batch FIFO and credit pool
  logic [TIME_W-1:0] batch_done_ns [DEPTH];
  int unsigned       batch_credits [DEPTH];
  int unsigned       head_idx;
  int unsigned       tail_idx;
  int unsigned       held_batches;
  int unsigned       free_credits;
  logic [CRED_W-1:0] max_credits_reg;

  // Predicted responses still owed by the block, oldest at status_rd
  rsp_t                    status_buf [STATUS_DEPTH];
  logic [STATUS_PTR_W-1:0] status_wr;
  logic [STATUS_PTR_W-1:0] status_rd;
  int unsigned             status_cnt;
  int unsigned             mismatches;
  int unsigned             responses_checked;

  function automatic int unsigned pool_of(logic [CRED_W-1:0] m);
    if (m == 0) return 1;
    if (m > DEPTH) return DEPTH;
    return 32'(m);
  endfunction

  task automatic empty_batches();
    head_idx     = 0;
    tail_idx     = 0;
    held_batches = 0;
    free_credits = pool_of(max_credits_reg);
  endtask

  // Return credits of every head batch completed at or before now_ns
  task automatic retire_due(input logic [63:0] now_ns);
    int unsigned pool;
    int unsigned sum;
    pool = pool_of(max_credits_reg);
    while (held_batches > 0 && {16'd0, batch_done_ns[head_idx]} <= now_ns) begin
      sum          = free_credits + batch_credits[head_idx];
      free_credits = (sum > pool) ? pool : sum;
      head_idx     = (head_idx + 1) % DEPTH;
      held_batches--;
    end
  endtask

  task automatic predict_credit_status(input req_t r, output rsp_t s);
    logic [63:0] now_ns;
    logic [63:0] delay;
    logic [63:0] head_ns;
    logic [63:0] wait_ns;
    logic [63:0] done_ns;
    int unsigned remaining;
    int unsigned pool;
    int unsigned batch;
    int unsigned use_cred;
    now_ns    = {16'd0, r.current_time};
    remaining = 32'(r.credits_needed);
    pool      = pool_of(max_credits_reg);
    delay     = '0;
    retire_due(now_ns);
    while (remaining > 0) begin
      batch = (remaining < pool) ? remaining : pool;
      while (free_credits < batch) begin
        if (held_batches > 0) begin
          head_ns = {16'd0, batch_done_ns[head_idx]};
          wait_ns = (head_ns > now_ns) ? head_ns - now_ns : 64'd0;
          delay   = delay + wait_ns;
          if (delay > TIME_SAT) delay = TIME_SAT;
          now_ns  = now_ns + wait_ns;
          retire_due(now_ns);
        end else begin
          free_credits = pool;
          break;
        end
      end
      use_cred     = (batch < free_credits) ? batch : free_credits;
      free_credits = free_credits - use_cred;
      done_ns      = now_ns + {48'd0, r.credit_latency};
      if (done_ns > TIME_SAT) done_ns = TIME_SAT;
      if (held_batches < DEPTH) begin
        batch_done_ns[tail_idx] = done_ns[TIME_W-1:0];
        batch_credits[tail_idx] = use_cred;
        tail_idx                = (tail_idx + 1) % DEPTH;
        held_batches++;
      end
      if (use_cred == 0) break;
      remaining = remaining - use_cred;
    end
    s.queue_delay       = delay[TIME_W-1:0];
    s.credits_left      = free_credits[CRED_W-1:0];
    s.entries_in_flight = held_batches[CNT_W-1:0];
  endtask

  task automatic check_status(input rsp_t got);
    rsp_t want;
    if (status_cnt == 0) begin
      $display("%0t: response with no request outstanding, got delay %0d credits %0d depth %0d",
               $time, got.queue_delay, got.credits_left, got.entries_in_flight);
      mismatches++;
    end else begin
      want      = status_buf[status_rd];
      status_rd = status_rd + 1'b1;
      status_cnt--;
      responses_checked++;
      if (got.queue_delay !== want.queue_delay) begin
        $display("%0t: queue_delay expected %0d, actual %0d",
                 $time, want.queue_delay, got.queue_delay);
        mismatches++;
      end
      if (got.credits_left !== want.credits_left) begin
        $display("%0t: credits_left expected %0d, actual %0d",
                 $time, want.credits_left, got.credits_left);
        mismatches++;
      end
      if (got.entries_in_flight !== want.entries_in_flight) begin
        $display("%0t: entries_in_flight expected %0d, actual %0d",
                 $time, want.entries_in_flight, got.entries_in_flight);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t predicted;
    if (!rst_ni) begin
      max_credits_reg   = MAX_CREDITS_RST;
      empty_batches();
      status_wr         = '0;
      status_rd         = '0;
      status_cnt        = 0;
      mismatches        = 0;
      responses_checked = 0;
    end else begin
      // compare first so a stray response is never matched to a fresh request
      if (rsp_valid_i && rsp_ready_i) check_status(rsp_data_i);
      if (cfg_valid_i && cfg_ready_i) begin
        max_credits_reg = cfg_data_i;
        empty_batches();
      end
      if (req_valid_i && req_ready_i) begin
        predict_credit_status(req_data_i, predicted);
        status_buf[status_wr] = predicted;
        status_wr             = status_wr + 1'b1;
        status_cnt++;
      end
    end
    err_count_o = mismatches;
    pending_o   = status_cnt;
    checked_o   = responses_checked;
  end

endmodule

// ----- tb/tb_credit_flow_control_tracker_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_credit_flow_control_tracker_top
// Drives requests and max_credits writes into the credit tracker under a
// range of pool sizes and idle mixes; a checker beside the block predicts
// and compares every response, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_credit_flow_control_tracker_top;
  import cftrk_pkg::*;

  localparam int unsigned DEPTH          = 128;
  localparam int unsigned NUM_SEGMENTS   = 8;
  localparam int unsigned SEG_ITEMS      = 75;
  localparam int unsigned SETTLE_CYCLES  = 30;
  localparam int unsigned HOLD_CYCLES    = 400;
  // A 1023-credit request at pool size one walks about a thousand batches
  // with no transaction on any channel; allow many times that.
  localparam int unsigned WATCHDOG_LIMIT = 200000;

  logic clk_i;
  logic rst_ni;

  cftrk_chan_if #(.T(req_t))              req_if ();
  cftrk_chan_if #(.T(rsp_t))              rsp_if ();
  cftrk_chan_if #(.T(logic [CRED_W-1:0])) cfg_if ();

  int unsigned       err_count;
  int unsigned       pending;
  int unsigned       checked;
  int unsigned       send_idle_pct = 0;
  int unsigned       rsp_stall_pct = 0;
  logic              start_hold    = 1'b0;
  int unsigned       sent_count    = 0;
  int unsigned       cfg_count     = 0;
  int unsigned       cur_pool      = 12;
  logic [TIME_W-1:0] req_time;
  int unsigned       idle_cycles;

  credit_flow_control_tracker_top #(
    .CREDIT_DEPTH (DEPTH)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req_if),
    .rsp    (rsp_if),
    .cfg    (cfg_if)
  );

  credit_status_checker #(
    .DEPTH (DEPTH)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_if.valid),
    .req_ready_i (req_if.ready),
    .req_data_i  (req_if.data),
    .rsp_valid_i (rsp_if.valid),
    .rsp_ready_i (rsp_if.ready),
    .rsp_data_i  (rsp_if.data),
    .cfg_valid_i (cfg_if.valid),
    .cfg_ready_i (cfg_if.ready),
    .cfg_data_i  (cfg_if.data),
    .err_count_o (err_count),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  // Free-running clock, 4 ns period
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Response sink: stall at the current rate; on request, hold ready low for
  // a long stretch so the output register fills and the block stalls input.
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (start_hold) begin
        start_hold = 1'b0;
        repeat (HOLD_CYCLES) begin
          rsp_if.ready <= 1'b0;
          @(posedge clk_i);
        end
      end
      rsp_if.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
    end
  end

  // Watchdog: end the run once no channel has moved a transaction for too long
  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("%0t: no transaction for %0d cycles, %0d responses outstanding",
             $time, idle_cycles, pending);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic req_t make_req(logic [TIME_W-1:0] t, logic [LAT_W-1:0] lat,
                                    logic [NEED_W-1:0] need);
    req_t r;
    r.current_time   = t;
    r.credit_latency = lat;
    r.credits_needed = need;
    return r;
  endfunction

  // Offer one request; idle first at the sender rate, then hold valid and
  // the payload until the transaction is taken. Valid stays high on return
  // so back-to-back requests need no second assignment in the same step.
  task automatic send_request(input req_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    do @(posedge clk_i); while (!req_if.ready);
    sent_count++;
  endtask

  // Drop valid and wait until every predicted response has come back, then
  // let the block settle a little longer.
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write max_credits only while the block is idle
  task automatic write_max_credits(input logic [CRED_W-1:0] value);
    wait_drained();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    cfg_count++;
    // codes 0 and above the depth fold into the legal pool range
    cur_pool = (value == 0) ? 1 : ((value > DEPTH) ? DEPTH : 32'(value));
  endtask

  // Mostly well-formed traffic: time advancing in steps comparable to the
  // latencies so batches sometimes retire and sometimes stall. The rest
  // steps time backwards or is fully random noise.
  task automatic next_random_request(output req_t r);
    int unsigned       roll;
    logic [LAT_W-1:0]  lat;
    logic [NEED_W-1:0] need;
    roll = $urandom_range(0, 99);
    lat  = ($urandom_range(0, 7) == 0) ? LAT_W'($urandom) : LAT_W'($urandom_range(0, 400));
    case ($urandom_range(0, 9))
      0:       need = '0;
      1, 2:    need = NEED_W'($urandom_range(0, cur_pool));
      default: need = NEED_W'($urandom_range(1, 2 * cur_pool));
    endcase
    if (roll < 85) begin
      if ($urandom_range(0, 3) != 0) req_time = req_time + TIME_W'($urandom_range(0, 300));
    end else if (roll < 95) begin
      req_time = req_time - TIME_W'($urandom_range(1, 500));
    end else begin
      req_time = TIME_W'({$urandom, $urandom});
      lat      = LAT_W'($urandom);
      need     = NEED_W'($urandom_range(0, 1023));
    end
    r = make_req(req_time, lat, need);
  endtask

  initial begin
    req_t              r;
    logic [CRED_W-1:0] seg_cfg [NUM_SEGMENTS];

    // Hold every input at a known value through reset
    rst_ni       <= 1'b0;
    req_if.valid <= 1'b0;
    req_if.data  <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset pool of 12, no idling
    send_request(make_req(48'd0, 16'd0, 10'd0));          // nothing to send
    send_request(make_req(48'd0, 16'd0, 10'd1));
    send_request(make_req(48'd10, 16'd100, 10'd12));      // drain whole pool
    send_request(make_req(48'd20, 16'd50, 10'd5));        // stall on the head
    send_request(make_req(48'd200, 16'd7, 10'd30));       // several batches
    send_request(make_req(48'd1000, 16'hFFFF, 10'h3FF));  // largest request
    send_request(make_req(48'd500, 16'd10, 10'd3));       // time going backwards
    send_request(make_req(TIME_MAX - 48'd10, 16'hFFFF, 10'd12)); // completion saturates
    send_request(make_req(TIME_MAX, 16'hFFFF, 10'd25));
    send_request(make_req(48'd0, 16'd0, 10'd12));         // far backwards, long wait
    send_request(make_req(48'd0, 16'd0, 10'd13));
    send_request(make_req(TIME_MAX, 16'd0, 10'd0));       // retire everything

    // Pool code zero acts as a pool of one
    write_max_credits(8'd0);
    send_request(make_req(48'd5, 16'd3, 10'd4));
    send_request(make_req(48'd5, 16'd0, 10'h3FF));
    send_request(make_req(48'd100, 16'hFFFF, 10'd2));

    // Pool code above the depth folds to the depth
    write_max_credits(8'hFF);
    send_request(make_req(48'd0, 16'd1000, 10'h3FF));
    send_request(make_req(48'd10, 16'd0, 10'd128));
    send_request(make_req(48'd20, 16'd5, 10'd129));
    send_request(make_req(48'd3000, 16'd40000, 10'd1));

    write_max_credits(8'd128);
    send_request(make_req(48'd5, 16'hFFFF, 10'd1));

    // Random segments, each with its own pool size and idle mix
    seg_cfg[0] = 8'd1;
    seg_cfg[1] = 8'd128;
    seg_cfg[2] = 8'd0;
    seg_cfg[3] = 8'd255;
    seg_cfg[4] = CRED_W'($urandom_range(2, 16));
    seg_cfg[5] = CRED_W'($urandom_range(17, 127));
    seg_cfg[6] = 8'd4;
    seg_cfg[7] = MAX_CREDITS_RST;

    for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
      write_max_credits(seg_cfg[seg]);
      case (seg % 4)
        0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
        1: begin send_idle_pct = 79; rsp_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  rsp_stall_pct = 79; end
        default: begin send_idle_pct = 29; rsp_stall_pct = 29; end
      endcase
      // one segment starts close to the top of the time range to hit wrap
      req_time = (seg == 3) ? TIME_MAX - 48'd30000 : TIME_W'({$urandom, $urandom});
      for (int i = 0; i < SEG_ITEMS; i++) begin
        // long receiver hold-off while the sender keeps offering
        if (seg == 4 && i == 5) start_hold = 1'b1;
        next_random_request(r);
        send_request(r);
      end
    end

    // Drain, then settle before the verdict
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    wait_drained();

    $display("Run covered %0d requests across %0d max_credits writes, pool sizes 1 to 128",
             sent_count, cfg_count);
    $display("and %0d responses compared under four idle mixes and one long hold-off.",
             checked);
    if (err_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
